// ===== design/drbe_pkg.sv =====
// Shared types and constants for the DER REAL binary encoder.
package drbe_pkg;

  typedef enum logic [2:0] {
    KIND_NORMAL,
    KIND_NAN,
    KIND_PINF,
    KIND_NINF,
    KIND_PZERO,
    KIND_NZERO,
    KIND_SUBN
  } kind_e;

  localparam logic [7:0] BYTE_NAN   = 8'h42;
  localparam logic [7:0] BYTE_PINF  = 8'h40;
  localparam logic [7:0] BYTE_NINF  = 8'h41;
  localparam logic [7:0] BYTE_NZERO = 8'h43;
  localparam logic [7:0] HDR_BINARY = 8'h80;
  localparam logic [7:0] HDR_NEG    = 8'h40;
  localparam logic [7:0] HDR_LONG   = 8'h01;

  localparam int unsigned MaxBytes = 10;

  typedef struct packed {
    logic        sign;
    logic [10:0] efield;
    logic [51:0] frac;
    kind_e       kind;
    logic [2:0]  nbytes;
  } cls_t;

  typedef struct packed {
    logic               sign;
    kind_e              kind;
    logic [2:0]         nbytes;
    logic [52:0]        mant;
    logic signed [11:0] expv;
  } aln_t;

  typedef struct packed {
    logic [8*MaxBytes-1:0] bytes;
    logic [3:0]            cnt;
    logic                  unsup;
  } pk_t;

endpackage

// ===== design/drbe_classify.sv =====
// Input capture and classification stages: special values and mantissa octet count.
module drbe_classify (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [63:0]         value_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output drbe_pkg::cls_t      out_o,
  input  logic                out_ready_i
);

  logic           in_v_q;
  logic [63:0]    in_q;
  logic           out_v_q;
  drbe_pkg::cls_t out_q;
  drbe_pkg::cls_t cls_d;
  logic           out_rdy;

  assign out_rdy    = !out_v_q || out_ready_i;
  assign in_ready_o = !in_v_q || out_rdy;

  always_comb begin
    cls_d.sign   = in_q[63];
    cls_d.efield = in_q[62:52];
    cls_d.frac   = in_q[51:0];
    cls_d.kind   = drbe_pkg::KIND_NORMAL;
    if (in_q[62:52] == 11'h7ff) begin
      if (in_q[51:0] != 52'd0) cls_d.kind = drbe_pkg::KIND_NAN;
      else if (in_q[63]) cls_d.kind = drbe_pkg::KIND_NINF;
      else cls_d.kind = drbe_pkg::KIND_PINF;
    end else if (in_q[62:52] == 11'd0) begin
      if (in_q[51:0] != 52'd0) cls_d.kind = drbe_pkg::KIND_SUBN;
      else if (in_q[63]) cls_d.kind = drbe_pkg::KIND_NZERO;
      else cls_d.kind = drbe_pkg::KIND_PZERO;
    end
    if (in_q[7:0] != 8'd0) cls_d.nbytes = 3'd7;
    else if (in_q[15:8] != 8'd0) cls_d.nbytes = 3'd6;
    else if (in_q[23:16] != 8'd0) cls_d.nbytes = 3'd5;
    else if (in_q[31:24] != 8'd0) cls_d.nbytes = 3'd4;
    else if (in_q[39:32] != 8'd0) cls_d.nbytes = 3'd3;
    else if (in_q[47:40] != 8'd0) cls_d.nbytes = 3'd2;
    else cls_d.nbytes = 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_ready_o) in_v_q <= in_valid_i;
      if (out_rdy) out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_q <= value_i;
    if (out_rdy && in_v_q) out_q <= cls_d;
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

endmodule

// ===== design/drbe_align.sv =====
// Mantissa trim and odd-forcing stages with exponent adjustment.
module drbe_align (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  drbe_pkg::cls_t in_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output drbe_pkg::aln_t out_o,
  input  logic           out_ready_i
);

  logic           mid_v_q;
  drbe_pkg::aln_t mid_q;
  drbe_pkg::aln_t mid_d;
  logic           out_v_q;
  drbe_pkg::aln_t out_q;
  drbe_pkg::aln_t out_d;
  logic           out_rdy;
  logic [52:0]    m53;
  logic [2:0]     tz;

  assign out_rdy    = !out_v_q || out_ready_i;
  assign in_ready_o = !mid_v_q || out_rdy;

  // trim trailing zero octets
  always_comb begin
    m53          = {1'b1, in_i.frac};
    mid_d.sign   = in_i.sign;
    mid_d.kind   = in_i.kind;
    mid_d.nbytes = in_i.nbytes;
    case (in_i.nbytes)
      3'd7:    mid_d.mant = m53;
      3'd6:    mid_d.mant = m53 >> 8;
      3'd5:    mid_d.mant = m53 >> 16;
      3'd4:    mid_d.mant = m53 >> 24;
      3'd3:    mid_d.mant = m53 >> 32;
      3'd2:    mid_d.mant = m53 >> 40;
      default: mid_d.mant = m53 >> 48;
    endcase
    mid_d.expv = $signed({1'b0, in_i.efield}) - 12'sd1019
               - $signed({6'd0, in_i.nbytes, 3'd0});
  end

  // shift right until odd; the low octet is never zero here
  always_comb begin
    tz = 3'd7;
    for (int i = 7; i >= 0; i--) begin
      if (mid_q.mant[i]) tz = 3'(i);
    end
    out_d      = mid_q;
    out_d.mant = mid_q.mant >> tz;
    out_d.expv = mid_q.expv + $signed({9'd0, tz});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_ready_o) mid_v_q <= in_valid_i;
      if (out_rdy) out_v_q <= mid_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) mid_q <= mid_d;
    if (out_rdy && mid_v_q) out_q <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

endmodule

// ===== design/drbe_pack.sv =====
// Octet packing stage: header, exponent and mantissa octets, left aligned.
module drbe_pack (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  drbe_pkg::aln_t in_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output drbe_pkg::pk_t  out_o,
  input  logic           out_ready_i
);

  logic          v_q;
  drbe_pkg::pk_t pk_q;
  drbe_pkg::pk_t pk_d;
  logic [55:0]   mal;
  logic [15:0]   e16;
  logic          short_exp;
  logic [7:0]    hdr;

  assign in_ready_o = !v_q || out_ready_i;

  always_comb begin
    case (in_i.nbytes)
      3'd7:    mal = {3'd0, in_i.mant};
      3'd6:    mal = {in_i.mant[47:0], 8'd0};
      3'd5:    mal = {in_i.mant[39:0], 16'd0};
      3'd4:    mal = {in_i.mant[31:0], 24'd0};
      3'd3:    mal = {in_i.mant[23:0], 32'd0};
      3'd2:    mal = {in_i.mant[15:0], 40'd0};
      default: mal = {in_i.mant[7:0], 48'd0};
    endcase
    e16       = 16'(in_i.expv);
    short_exp = (in_i.expv >= -12'sd128) && (in_i.expv <= 12'sd127);
    hdr       = drbe_pkg::HDR_BINARY | (in_i.sign ? drbe_pkg::HDR_NEG : 8'd0);
    pk_d.unsup = 1'b0;
    pk_d.cnt   = 4'd1;
    pk_d.bytes = '0;
    case (in_i.kind)
      drbe_pkg::KIND_NORMAL: begin
        if (short_exp) begin
          pk_d.bytes = {hdr, e16[7:0], mal, 8'd0};
          pk_d.cnt   = 4'd2 + {1'b0, in_i.nbytes};
        end else begin
          pk_d.bytes = {hdr | drbe_pkg::HDR_LONG, e16[15:8], e16[7:0], mal};
          pk_d.cnt   = 4'd3 + {1'b0, in_i.nbytes};
        end
      end
      drbe_pkg::KIND_NAN:   pk_d.bytes = {drbe_pkg::BYTE_NAN, 72'd0};
      drbe_pkg::KIND_PINF:  pk_d.bytes = {drbe_pkg::BYTE_PINF, 72'd0};
      drbe_pkg::KIND_NINF:  pk_d.bytes = {drbe_pkg::BYTE_NINF, 72'd0};
      drbe_pkg::KIND_NZERO: pk_d.bytes = {drbe_pkg::BYTE_NZERO, 72'd0};
      drbe_pkg::KIND_SUBN:  pk_d.unsup = 1'b1;
      default:              pk_d.cnt   = 4'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) pk_q <= pk_d;
  end

  assign out_valid_o = v_q;
  assign out_o       = pk_q;

endmodule

// ===== design/drbe_serializer.sv =====
// Output serializer: shifts one packed item out one octet per cycle.
module drbe_serializer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  drbe_pkg::pk_t in_i,
  output logic          in_ready_o,
  output logic          strobe_o,
  output logic [7:0]    out_byte_o,
  output logic          last_byte_o,
  output logic          unsupported_o
);

  logic                            v_q;
  logic [3:0]                      cnt_q;
  logic [8*drbe_pkg::MaxBytes-1:0] buf_q;
  logic                            unsup_q;

  assign in_ready_o = !v_q || (cnt_q == 4'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= 1'b0;
      cnt_q <= 4'd0;
    end else if (in_ready_o && in_valid_i) begin
      v_q   <= (in_i.cnt != 4'd0);
      cnt_q <= in_i.cnt;
    end else if (v_q) begin
      v_q   <= (cnt_q != 4'd1);
      cnt_q <= cnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      buf_q   <= in_i.bytes;
      unsup_q <= in_i.unsup;
    end else if (v_q) begin
      buf_q <= {buf_q[8*drbe_pkg::MaxBytes-9:0], 8'd0};
    end
  end

  assign strobe_o      = v_q;
  assign out_byte_o    = buf_q[8*drbe_pkg::MaxBytes-1 -: 8];
  assign last_byte_o   = (cnt_q == 4'd1);
  assign unsupported_o = unsup_q;

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q |-> (cnt_q != 4'd0) && (cnt_q <= 4'(drbe_pkg::MaxBytes)))
    else $error("serializer count out of range");

  a_unsup_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q && unsup_q |-> cnt_q == 4'd1)
    else $error("unsupported beat is not a single beat");

  a_no_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q && (cnt_q != 4'd1) |=> v_q && (cnt_q == $past(cnt_q) - 4'd1))
    else $error("item beats not contiguous");

endmodule

// ===== design/der_real_binary_encoder_top.sv =====
// DER REAL (binary, base 2) content octet encoder, top level.
// Takes a raw binary64 pattern on start/busy and streams the content octets one beat
// per cycle on strobe_o, last_byte_o marking the final beat of an item. The receiver
// cannot hold beats off: each beat is on the ports for its one strobe cycle only.
// On acceptance a value passes the classify in and out registers, the align mid and out
// registers and the pack register before it loads the serializer buffer. The output
// runs at one octet per cycle; an item has one octet for a special value, three to ten
// for a normal value, none for plus zero. The item rate is set by the octet serializer;
// the five pipeline stages ahead of it absorb short bursts, and busy rises once they fill.
module der_real_binary_encoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] value_bits_i,
  output logic        strobe_o,
  output logic [7:0]  out_byte_o,
  output logic        last_byte_o,
  output logic        unsupported_o
);

  logic           in_ready;
  logic           cls_v;
  logic           cls_rdy;
  drbe_pkg::cls_t cls;
  logic           aln_v;
  logic           aln_rdy;
  drbe_pkg::aln_t aln;
  logic           pk_v;
  logic           pk_rdy;
  drbe_pkg::pk_t  pk;

  assign busy = !in_ready;

  drbe_classify u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (start),
    .value_i     (value_bits_i),
    .in_ready_o  (in_ready),
    .out_valid_o (cls_v),
    .out_o       (cls),
    .out_ready_i (cls_rdy)
  );

  drbe_align u_align (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cls_v),
    .in_i        (cls),
    .in_ready_o  (cls_rdy),
    .out_valid_o (aln_v),
    .out_o       (aln),
    .out_ready_i (aln_rdy)
  );

  drbe_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (aln_v),
    .in_i        (aln),
    .in_ready_o  (aln_rdy),
    .out_valid_o (pk_v),
    .out_o       (pk),
    .out_ready_i (pk_rdy)
  );

  drbe_serializer u_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (pk_v),
    .in_i          (pk),
    .in_ready_o    (pk_rdy),
    .strobe_o      (strobe_o),
    .out_byte_o    (out_byte_o),
    .last_byte_o   (last_byte_o),
    .unsupported_o (unsupported_o)
  );

endmodule
